### rtl/core/scpm_pkg.sv
package scpm_pkg;

   localparam int MAX_POSES = 256;
   localparam int CHANNELS  = 7;
   localparam int VAL_W     = 32;
   localparam int ADDR_W    = $clog2(MAX_POSES);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int SUM_W     = VAL_W + ADDR_W + 1;
   localparam int SQ_W      = 2 * VAL_W + ADDR_W;
   localparam int NM_W      = SQ_W + 1;
   localparam int DEV_W     = SQ_W / 2;
   localparam int DIFF_W    = VAL_W + 1;
   localparam int REQ_DATA_W = CHANNELS * VAL_W;
   localparam int RSP_BITS   = CHANNELS * VAL_W + 2 * CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FEW      = 2'd1,
      STATUS_NONE     = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic              load;
      logic              clear;
      logic              start_stats;
      logic              start_kmean;
      logic              rd;
      logic              keep;
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  n;
      logic [CNT_W-1:0]  kept;
   } lane_cmd_type;

   typedef struct packed {
      logic stats_rdy;
      logic kmean_rdy;
      logic ok;
   } lane_sts_type;

endpackage

### rtl/core/sigma_clipped_pose_mean.sv
// Channel   Direction  Ports          Contents
// request   in         req_t*         one pose per transaction, tlast ends the set
// response  out        rsp_t*         clipped mean, counts and status per set
//
// Each accepted pose is written into the lanes' stores while room is left. After
// the closing pose the seven lanes work side by side: mean and deviation
// (serial divider and root unit in each lane), the clipping scan through
// each lane's store, then the kept mean. Reset is synchronous and active
// high and empties the store; the store itself needs no clearing. The
// request side is held off from the closing pose until the response
// transaction has been taken.
module sigma_clipped_pose_mean (
   input  logic                               clock,
   input  logic                               reset,
   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w (32 bits each)
   input  logic [scpm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // mean_pos_x .. mean_quat_w (32 bits each), total_count, kept_count, zero fill
   output logic [scpm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);

   // Sequencer of the whole set; the lanes hold their own arithmetic steps.
   typedef enum logic [8:0] {
      ST_LOAD     = 9'b000000001,
      ST_CHECK    = 9'b000000010,
      ST_STATS_GO = 9'b000000100,
      ST_STATS    = 9'b000001000,
      ST_SCAN     = 9'b000010000,
      ST_DRAIN    = 9'b000100000,
      ST_KGO      = 9'b001000000,
      ST_KWAIT    = 9'b010000000,
      ST_OUT      = 9'b100000000
   } state_type;

   localparam int CH = scpm_pkg::CHANNELS;
   localparam int VW = scpm_pkg::VAL_W;

   state_type                   st_ff, st_in;
   logic [scpm_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [scpm_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [scpm_pkg::CNT_W-1:0]  kept_ff, kept_in;
   logic                        ovf_ff, ovf_in;
   logic                        svld_ff;
   scpm_pkg::status_type        status_ff, status_in;

   scpm_pkg::lane_cmd_type      cmd;
   scpm_pkg::lane_sts_type      sts [CH];
   logic [VW-1:0]               kmean [CH];
   logic [CH-1:0]               ok_vec, srdy_vec, krdy_vec;
   logic                        accept, keep, can_store;

   assign accept    = req_tvalid && req_tready;
   assign can_store = cnt_ff < scpm_pkg::CNT_W'(scpm_pkg::MAX_POSES);

   // The merge: a pose is kept only when every lane finds it within range.
   always_comb begin
      for (int c = 0; c < CH; c++) begin
         ok_vec[c]   = sts[c].ok;
         srdy_vec[c] = sts[c].stats_rdy;
         krdy_vec[c] = sts[c].kmean_rdy;
      end
   end
   assign keep = svld_ff && (&ok_vec);

   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      kept_in   = kept_ff;
      ovf_in    = ovf_ff;
      status_in = status_ff;

      cmd             = '0;
      cmd.n           = cnt_ff;
      cmd.kept        = kept_ff;
      cmd.keep        = keep;
      cmd.addr        = cnt_ff[scpm_pkg::ADDR_W-1:0];

      unique case (st_ff)
         ST_LOAD: begin
            if (accept) begin
               if (can_store) begin
                  cmd.load = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  st_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (ovf_ff) begin
               status_in = scpm_pkg::STATUS_OVERFLOW;
               st_in     = ST_OUT;
            end else if (cnt_ff < scpm_pkg::CNT_W'(2)) begin
               status_in = scpm_pkg::STATUS_FEW;
               st_in     = ST_OUT;
            end else begin
               st_in = ST_STATS_GO;
            end
         end
         ST_STATS_GO: begin
            cmd.start_stats = 1'b1;
            kept_in         = '0;
            idx_in          = '0;
            st_in           = ST_STATS;
         end
         ST_STATS: begin
            if (&srdy_vec) begin
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd   = 1'b1;
            cmd.addr = idx_ff[scpm_pkg::ADDR_W-1:0];
            idx_in   = idx_ff + 1'b1;
            if (keep) begin
               kept_in = kept_ff + 1'b1;
            end
            if (idx_ff == cnt_ff - 1'b1) begin
               st_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (keep) begin
               kept_in = kept_ff + 1'b1;
            end
            st_in = ST_KGO;
         end
         ST_KGO: begin
            if (kept_ff == '0) begin
               status_in = scpm_pkg::STATUS_NONE;
               st_in     = ST_OUT;
            end else begin
               cmd.start_kmean = 1'b1;
               status_in       = scpm_pkg::STATUS_OK;
               st_in           = ST_KWAIT;
            end
         end
         ST_KWAIT: begin
            if (&krdy_vec) begin
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cmd.clear = 1'b1;
               cnt_in    = '0;
               ovf_in    = 1'b0;
               st_in     = ST_LOAD;
            end
         end
         default: st_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_LOAD;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         svld_ff   <= 1'b0;
         kept_ff   <= '0;
         status_ff <= scpm_pkg::STATUS_OK;
      end else begin
         st_ff     <= st_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         svld_ff   <= cmd.rd;
         kept_ff   <= kept_in;
         status_ff <= status_in;
      end
      idx_ff <= idx_in;
   end

   for (genvar c = 0; c < CH; c++) begin : g_lane
      scpm_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .wdata (req_tdata[c*VW +: VW]),
         .sts   (sts[c]),
         .kmean (kmean[c])
      );
   end

   // Error results carry zero means and a zero kept count.
   always_comb begin
      rsp_tdata = '0;
      for (int c = 0; c < CH; c++) begin
         rsp_tdata[c*VW +: VW] = (status_ff == scpm_pkg::STATUS_OK) ? kmean[c] : '0;
      end
      rsp_tdata[CH*VW +: scpm_pkg::CNT_W] = cnt_ff;
      rsp_tdata[CH*VW + scpm_pkg::CNT_W +: scpm_pkg::CNT_W] =
         (status_ff == scpm_pkg::STATUS_OK) ? kept_ff : '0;
   end

   assign rsp_tuser  = status_ff;
   assign rsp_tvalid = (st_ff == ST_OUT);
   assign req_tready = (st_ff == ST_LOAD);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response sides open together");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= scpm_pkg::CNT_W'(scpm_pkg::MAX_POSES))
      else $error("pose count beyond store depth");

   a_ok_has_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status_ff == scpm_pkg::STATUS_OK) |-> (kept_ff != '0))
      else $error("good result with no kept pose");

   // The kept count only means something on a good result.
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status_ff == scpm_pkg::STATUS_OK) |-> (kept_ff <= cnt_ff))
      else $error("more poses kept than stored");

endmodule

### rtl/core/scpm_div.sv
module scpm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [scpm_pkg::SQ_W-1:0]   numer,
   input  logic [scpm_pkg::CNT_W-1:0]  denom,
   output logic                        done,
   output logic [scpm_pkg::SQ_W-1:0]   quot
);
   // Restoring divider, one quotient bit per cycle.
   localparam int CW = $clog2(scpm_pkg::SQ_W);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [scpm_pkg::SQ_W-1:0]    q_ff, q_in;
   logic [scpm_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [scpm_pkg::CNT_W-1:0]   den_ff, den_in;
   logic [scpm_pkg::CNT_W:0]     trial;

   assign trial = {rem_ff, q_ff[scpm_pkg::SQ_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = scpm_pkg::CNT_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[scpm_pkg::SQ_W-2:0], 1'b1};
         end else begin
            rem_in = trial[scpm_pkg::CNT_W-1:0];
            q_in   = {q_ff[scpm_pkg::SQ_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(scpm_pkg::SQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### rtl/core/scpm_isqrt.sv
module scpm_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [scpm_pkg::SQ_W-1:0]   radicand,
   output logic                        done,
   output logic [scpm_pkg::DEV_W-1:0]  root
);
   // Digit-by-digit square root, two radicand bits per cycle.
   localparam int CW = $clog2(scpm_pkg::DEV_W);
   localparam int RW = scpm_pkg::DEV_W + 2;

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [scpm_pkg::SQ_W-1:0]    v_ff, v_in;
   logic [scpm_pkg::DEV_W-1:0]   root_ff, root_in;
   logic [RW-1:0]                rem_ff, rem_in;
   logic [RW+1:0]                rn, trial;

   assign rn    = {rem_ff, v_ff[scpm_pkg::SQ_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         v_in = {v_ff[scpm_pkg::SQ_W-3:0], 2'b00};
         if (rn >= trial) begin
            rem_in  = RW'(rn - trial);
            root_in = {root_ff[scpm_pkg::DEV_W-2:0], 1'b1};
         end else begin
            rem_in  = rn[RW-1:0];
            root_in = {root_ff[scpm_pkg::DEV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(scpm_pkg::DEV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      v_ff    <= v_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/core/scpm_lane.sv
module scpm_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  scpm_pkg::lane_cmd_type      cmd,
   input  logic [scpm_pkg::VAL_W-1:0]  wdata,
   output scpm_pkg::lane_sts_type      sts,
   output logic [scpm_pkg::VAL_W-1:0]  kmean
);
   // One channel: its column of the store, running sums, mean, deviation,
   // the clipping test and the sum of the kept values.
   typedef enum logic [5:0] {
      L_IDLE = 6'b000001,
      L_MDIV = 6'b000010,
      L_NM2  = 6'b000100,
      L_VDIV = 6'b001000,
      L_SQRT = 6'b010000,
      L_KDIV = 6'b100000
   } lstate_type;

   localparam int VW = scpm_pkg::VAL_W;

   lstate_type                   st_ff, st_in;
   logic [VW-1:0]                mem [scpm_pkg::MAX_POSES];
   logic [VW-1:0]                rdata_ff;
   logic [VW-1:0]                x_ff;
   logic                         xv_ff;
   logic signed [scpm_pkg::SUM_W-1:0] sum_ff, ksum_ff;
   logic [scpm_pkg::SQ_W-1:0]    sq_ff;
   logic [VW-1:0]                mean_ff, mean_in;
   logic [VW-1:0]                kmean_ff, kmean_in;
   logic [scpm_pkg::DEV_W-1:0]   dev_ff;
   logic [scpm_pkg::NM_W-1:0]    mm2_ff, mm2_in, acc_ff, acc_in;
   logic [scpm_pkg::CNT_W-1:0]   nsh_ff, nsh_in;
   logic [3:0]                   step_ff, step_in;
   logic                         srdy_ff, srdy_in, krdy_ff, krdy_in;

   logic                         div_start, div_done, sq_start, sq_done;
   logic [scpm_pkg::SQ_W-1:0]    div_num, div_q;
   logic [scpm_pkg::CNT_W-1:0]   div_den;
   logic [scpm_pkg::DEV_W-1:0]   sq_root;
   logic [VW-1:0]                xmag;
   logic [scpm_pkg::SUM_W-1:0]   sum_mag, ksum_mag;
   logic [scpm_pkg::SQ_W-1:0]    var_num;
   logic signed [scpm_pkg::DIFF_W-1:0] dlt;
   logic [scpm_pkg::DIFF_W-1:0]  dmag;

   assign xmag     = x_ff[VW-1] ? VW'(-x_ff) : x_ff;
   assign sum_mag  = sum_ff[scpm_pkg::SUM_W-1] ? scpm_pkg::SUM_W'(-sum_ff) : sum_ff;
   assign ksum_mag = ksum_ff[scpm_pkg::SUM_W-1] ? scpm_pkg::SUM_W'(-ksum_ff) : ksum_ff;
   assign var_num  = ({1'b0, sq_ff} > acc_ff) ? scpm_pkg::SQ_W'({1'b0, sq_ff} - acc_ff) : '0;

   assign dlt  = $signed({rdata_ff[VW-1], rdata_ff}) - $signed({mean_ff[VW-1], mean_ff});
   assign dmag = dlt[scpm_pkg::DIFF_W-1] ? scpm_pkg::DIFF_W'(-dlt) : scpm_pkg::DIFF_W'(dlt);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem[cmd.addr] <= wdata;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   always_comb begin
      st_in     = st_ff;
      mean_in   = mean_ff;
      kmean_in  = kmean_ff;
      mm2_in    = mm2_ff;
      acc_in    = acc_ff;
      nsh_in    = nsh_ff;
      step_in   = step_ff;
      srdy_in   = srdy_ff;
      krdy_in   = krdy_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = cmd.n;
      sq_start  = 1'b0;
      unique case (st_ff)
         L_IDLE: begin
            if (cmd.start_stats) begin
               div_start = 1'b1;
               div_num   = scpm_pkg::SQ_W'(sum_mag);
               srdy_in   = 1'b0;
               st_in     = L_MDIV;
            end else if (cmd.start_kmean) begin
               div_start = 1'b1;
               div_num   = scpm_pkg::SQ_W'(ksum_mag);
               div_den   = cmd.kept;
               krdy_in   = 1'b0;
               st_in     = L_KDIV;
            end
         end
         L_MDIV: begin
            if (div_done) begin
               mean_in = sum_ff[scpm_pkg::SUM_W-1] ? VW'(-div_q[VW-1:0]) : div_q[VW-1:0];
               mm2_in  = scpm_pkg::NM_W'(div_q[VW-1:0] * div_q[VW-1:0]);
               acc_in  = '0;
               nsh_in  = cmd.n;
               step_in = '0;
               st_in   = L_NM2;
            end
         end
         L_NM2: begin
            // n times the squared mean by shift and add over the bits of n.
            if (step_ff == 4'(scpm_pkg::CNT_W)) begin
               div_start = 1'b1;
               div_num   = var_num;
               div_den   = scpm_pkg::CNT_W'(cmd.n - 1'b1);
               st_in     = L_VDIV;
            end else begin
               if (nsh_ff[0]) begin
                  acc_in = scpm_pkg::NM_W'(acc_ff + mm2_ff);
               end
               mm2_in  = {mm2_ff[scpm_pkg::NM_W-2:0], 1'b0};
               nsh_in  = nsh_ff >> 1;
               step_in = step_ff + 1'b1;
            end
         end
         L_VDIV: begin
            if (div_done) begin
               sq_start = 1'b1;
               st_in    = L_SQRT;
            end
         end
         L_SQRT: begin
            if (sq_done) begin
               srdy_in = 1'b1;
               st_in   = L_IDLE;
            end
         end
         L_KDIV: begin
            if (div_done) begin
               kmean_in = ksum_ff[scpm_pkg::SUM_W-1] ? VW'(-div_q[VW-1:0])
                                                     : div_q[VW-1:0];
               krdy_in  = 1'b1;
               st_in    = L_IDLE;
            end
         end
         default: st_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         srdy_ff <= 1'b0;
         krdy_ff <= 1'b0;
         xv_ff   <= 1'b0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         ksum_ff <= '0;
      end else begin
         st_ff   <= st_in;
         srdy_ff <= srdy_in;
         krdy_ff <= krdy_in;
         xv_ff   <= cmd.load;
         if (cmd.clear) begin
            sum_ff  <= '0;
            sq_ff   <= '0;
            ksum_ff <= '0;
         end else begin
            if (xv_ff) begin
               sum_ff <= sum_ff + scpm_pkg::SUM_W'($signed(x_ff));
               sq_ff  <= sq_ff + scpm_pkg::SQ_W'(xmag * xmag);
            end
            if (cmd.keep) begin
               ksum_ff <= ksum_ff + scpm_pkg::SUM_W'($signed(rdata_ff));
            end
         end
      end
      x_ff     <= wdata;
      mean_ff  <= mean_in;
      kmean_ff <= kmean_in;
      mm2_ff   <= mm2_in;
      acc_ff   <= acc_in;
      nsh_ff   <= nsh_in;
      step_ff  <= step_in;
      if (sq_done) begin
         dev_ff <= sq_root;
      end
   end

   scpm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   scpm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (div_q),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign sts.stats_rdy = srdy_ff;
   assign sts.kmean_rdy = krdy_ff;
   assign sts.ok        = {{(scpm_pkg::DEV_W-scpm_pkg::DIFF_W){1'b0}}, dmag} <= dev_ff;
   assign kmean         = kmean_ff;

endmodule

### test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VAL_W      = scpm_pkg::VAL_W;
   localparam int CHANNELS   = scpm_pkg::CHANNELS;
   localparam int CNT_W      = scpm_pkg::CNT_W;
   localparam int MAX_POSES  = scpm_pkg::MAX_POSES;
   localparam int REQ_DATA_W = scpm_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = scpm_pkg::RSP_DATA_W;

   // Pose of seven signed Q16.16 channels, as it travels on req_tdata.
   typedef logic signed [VAL_W-1:0] pose_type [CHANNELS];

   // Predicted result of one set of poses.
   typedef struct {
      logic [VAL_W-1:0]     mean [CHANNELS];
      logic [CNT_W-1:0]     total;
      logic [CNT_W-1:0]     kept;
      scpm_pkg::status_type status;
   } clip_result_type;

   // Scoreboard: keeps its own copy of the pose store, works out the clipped
   // mean whenever a closing pose is noted, and checks responses in order.
   class clip_scoreboard;
      longint          store [MAX_POSES][CHANNELS];
      int              count;
      bit              overflow;
      clip_result_type pending [$];
      int              mismatches;

      function new();
         count = 0;
         overflow = 0;
         mismatches = 0;
      endfunction

      function void note_pose(pose_type p, bit last);
         clip_result_type r;
         longint          mean [CHANNELS];
         longint          dev [CHANNELS];
         longint          ksum [CHANNELS];
         longint          sum, dd;
         logic [127:0]    sq, nm2, v, cand;
         longint          mm;
         int              kept;
         bit              keep;
         if (count < MAX_POSES) begin
            for (int c = 0; c < CHANNELS; c++) store[count][c] = p[c];
            count++;
         end else begin
            overflow = 1;
         end
         if (!last) return;
         kept = 0;
         for (int c = 0; c < CHANNELS; c++) ksum[c] = 0;
         if (overflow) r.status = scpm_pkg::STATUS_OVERFLOW;
         else if (count < 2) r.status = scpm_pkg::STATUS_FEW;
         else begin
            for (int c = 0; c < CHANNELS; c++) begin
               sum = 0;
               sq = 0;
               for (int i = 0; i < count; i++) begin
                  sum += store[i][c];
                  mm = store[i][c] < 0 ? -store[i][c] : store[i][c];
                  sq += 128'(mm) * 128'(mm);
               end
               // Division of longint truncates toward zero, as required.
               mean[c] = sum / count;
               mm = mean[c] < 0 ? -mean[c] : mean[c];
               nm2 = 128'(mm) * 128'(mm) * 128'(count);
               if (sq <= nm2) v = 0;
               else v = (sq - nm2) / 128'(count - 1);
               dev[c] = 0;
               for (int b = 63; b >= 0; b--) begin
                  cand = 128'(dev[c]) | (128'(1) << b);
                  if (cand * cand <= v) dev[c] = longint'(cand);
               end
            end
            for (int i = 0; i < count; i++) begin
               keep = 1;
               for (int c = 0; c < CHANNELS; c++) begin
                  dd = store[i][c] - mean[c];
                  if (dd < 0) dd = -dd;
                  if (dd > dev[c]) keep = 0;
               end
               if (keep) begin
                  kept++;
                  for (int c = 0; c < CHANNELS; c++) ksum[c] += store[i][c];
               end
            end
            r.status = kept == 0 ? scpm_pkg::STATUS_NONE : scpm_pkg::STATUS_OK;
         end
         for (int c = 0; c < CHANNELS; c++)
            r.mean[c] = r.status == scpm_pkg::STATUS_OK ? VAL_W'(ksum[c] / kept) : '0;
         r.total = CNT_W'(count);
         r.kept = r.status == scpm_pkg::STATUS_OK ? CNT_W'(kept) : '0;
         pending.insert(pending.size(), r);
         count = 0;
         overflow = 0;
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic [1:0] user);
         clip_result_type e;
         bit              bad;
         logic [CNT_W-1:0] tot, kp;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response transaction %h", data);
            return;
         end
         e = pending.pop_front();
         bad = 0;
         for (int c = 0; c < CHANNELS; c++)
            if (data[c*VAL_W +: VAL_W] !== e.mean[c]) bad = 1;
         tot = data[CHANNELS*VAL_W +: CNT_W];
         kp = data[CHANNELS*VAL_W+CNT_W +: CNT_W];
         if (tot !== e.total || kp !== e.kept || user !== e.status) bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch: expected status %0d total %0d kept %0d, got %0d %0d %0d",
                        e.status, e.total, e.kept, user, tot, kp);
               for (int c = 0; c < CHANNELS; c++)
                  $display("   channel %0d expected %h got %h", c, e.mean[c],
                           data[c*VAL_W +: VAL_W]);
            end
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 0;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;

   clip_scoreboard board = new();
   bit             hold_rsp = 0;
   int             burst_left = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   sigma_clipped_pose_mean i_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   // Responses are sampled at the rising edge; tready is changed at the
   // falling edge on a stall pattern of its own, or held low while a long
   // hold-off is in force.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);

   always @(negedge clock) begin
      if (hold_rsp) rsp_tready <= 0;
      else if (burst_left > 0) begin
         burst_left <= burst_left - 1;
      end else begin
         rsp_tready <= $urandom_range(0, 2) != 0;
         burst_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
      end
   end

   // Sends one pose and waits for its transaction. Within a burst tvalid
   // stays high from pose to pose; between bursts it drops for a random gap.
   int gap_left = 0;
   task automatic send_pose(pose_type p, bit last);
      if (gap_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         gap_left = $urandom_range(1, 16);
      end
      gap_left--;
      for (int c = 0; c < CHANNELS; c++) req_tdata[c*VAL_W +: VAL_W] <= p[c];
      req_tlast <= last;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      board.note_pose(p, last);
      @(negedge clock);
   endtask

   // Random channel value: mostly near a centre with a spread, sometimes wild.
   function automatic logic [VAL_W-1:0] pick_value(int centre, int spread);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return VAL_W'(centre + int'($urandom_range(0, 2*spread)) - spread);
      endcase
   endfunction

   task automatic send_set(int n);
      pose_type p;
      int       centre [CHANNELS];
      int       spread;
      spread = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 1 << 20);
      for (int c = 0; c < CHANNELS; c++) centre[c] = $urandom();
      for (int i = 0; i < n; i++) begin
         for (int c = 0; c < CHANNELS; c++) p[c] = pick_value(centre[c], spread);
         send_pose(p, i == n - 1);
      end
   endtask

   task automatic send_const_set(int n, logic [VAL_W-1:0] v);
      pose_type p;
      for (int c = 0; c < CHANNELS; c++) p[c] = v;
      for (int i = 0; i < n; i++) send_pose(p, i == n - 1);
   endtask

   int sent;
   int n;
   pose_type q;

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed sets: a lone pose, extremes, two apart (none kept unless
      // the deviation covers both), a constant set, small random sets, store overflow and a full store.
      send_const_set(1, 32'h0001_0000);
      send_const_set(2, 32'h8000_0000);
      send_const_set(2, 32'h7fff_ffff);
      send_const_set(3, 32'hffff_ffff);
      for (int c = 0; c < CHANNELS; c++) q[c] = 32'h8000_0000;
      send_pose(q, 0);
      for (int c = 0; c < CHANNELS; c++) q[c] = 32'h7fff_ffff;
      send_pose(q, 1);
      send_set(5);
      send_set(4);
      send_const_set(MAX_POSES + 2, 32'h1234_5678);
      send_set(MAX_POSES);
      sent = 2 * MAX_POSES + 20;

      // Long hold-off on the response side while the sender keeps offering.
      fork
         begin
            hold_rsp = 1;
            repeat (2000) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            send_set(3);
            send_set(4);
         end
      join

      while (sent < 750) begin
         n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 12);
         send_set(n);
         sent += n;
      end
      req_tvalid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
